// File: src/point_to_landmark_lookat_frame_unit_assert.svh
// Assertion macros for the landmark look-at frame unit.
// Expects clk and rst_n in the scope of use.
`ifndef POINT_TO_LANDMARK_LOOKAT_FRAME_UNIT_ASSERT_SVH
`define POINT_TO_LANDMARK_LOOKAT_FRAME_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTLF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`define PTLF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PTLF_ASSERT_NEVER(label, cond, msg)
`define PTLF_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// File: src/ptlf_pkg.sv
// Shared widths, codes and output rounding for the landmark look-at frame unit.
// No dependencies.
package ptlf_pkg;
    localparam int COORD_BITS     = 32;
    localparam int AXIS_FRAC_BITS = 14;
    localparam int AXIS_BITS      = AXIS_FRAC_BITS + 2;
    localparam int UNIT_FRAC      = 31;
    localparam int MAG_BITS       = COORD_BITS + 1;
    localparam int RAD_BITS       = 68;
    localparam int ROOT_BITS      = RAD_BITS / 2;
    localparam int DIVN_BITS      = 66;
    localparam int DIVD_BITS      = 65;
    localparam int QUO_BITS       = 33;
    localparam int UNIT_SHIFT     = UNIT_FRAC - AXIS_FRAC_BITS;
    localparam int PROD_SHIFT     = 2 * UNIT_FRAC - AXIS_FRAC_BITS;

    localparam logic [1:0] OP_SET_LANDMARK = 2'd0;
    localparam logic [1:0] OP_CLEAR        = 2'd1;
    localparam logic [1:0] OP_NEW_POINT    = 2'd2;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_CLEARED = 1'b1;

    function automatic logic [AXIS_BITS-1:0] to_axis(input logic [31:0] q, input logic neg);
        logic [32:0]          r;
        logic [AXIS_BITS-1:0] m;
        r = ({1'b0, q} + (33'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
        m = r[AXIS_BITS-1:0];
        return neg ? -m : m;
    endfunction

    function automatic logic [AXIS_BITS-1:0] prod_axis(input logic [63:0] p, input logic neg);
        logic [63:0]          r;
        logic [AXIS_BITS-1:0] m;
        r = (p + (64'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
        m = r[AXIS_BITS-1:0];
        return neg ? -m : m;
    endfunction
endpackage

// File: src/ptlf_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on ptlf_pkg.
module ptlf_sqrt
    import ptlf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_BITS-1:0]  radicand,
    output logic [ROOT_BITS-1:0] root,
    output logic                 done,
    output logic                 busy
);
    logic [RAD_BITS-1:0]  rad_reg;
    logic [36:0]          rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [36:0]          shifted;
    logic [36:0]          trial;
    logic                 fits;

    assign shifted = {rem_reg[34:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(ROOT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? shifted - trial : shifted;
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;
    assign busy = busy_reg;
endmodule

// File: src/ptlf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ptlf_pkg; quotient must fit QUO_BITS bits.
module ptlf_div
    import ptlf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIVN_BITS-1:0] num,
    input  logic [DIVD_BITS-1:0] den,
    output logic [QUO_BITS-1:0]  quo,
    output logic                 done,
    output logic                 busy
);
    logic [DIVN_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]  low_reg;
    logic [DIVD_BITS-1:0] den_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVN_BITS-1:0] trial;
    logic                 fits;

    assign trial = {rem_reg[DIVN_BITS-2:0], low_reg[QUO_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QUO_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DIVN_BITS-QUO_BITS){1'b0}}, num[DIVN_BITS-1 -: DIVN_BITS-QUO_BITS]};
            low_reg <= num[QUO_BITS-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;
    assign busy = busy_reg;
endmodule

// File: src/point_to_landmark_lookat_frame_unit.sv
// Landmark look-at frame unit: holds a landmark and a tracked point, and for each
// measurement returns their Euclidean distance and a look-at frame in Q1.14.
// A measurement runs three passes of the 34-step root unit, six passes of the 33-step
// divider, and single-bit normalizing shifts between them; s_axis_tready is low
// throughout. A degenerate direction ends early: a zero direction after the first root
// pass, one along z after the normalizing shifts.
// A result waiting on the output does not block acceptance of the next input beat.
// Depends on ptlf_pkg, ptlf_sqrt, ptlf_div and the assertion macro header.
`include "point_to_landmark_lookat_frame_unit_assert.svh"
module point_to_landmark_lookat_frame_unit
    import ptlf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // coord_x, coord_y, coord_z
    input  logic [1:0]   s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,   // distance, right_x/y/z, up_x/y/z, front_x/y/z
    output logic [1:0]   m_axis_tuser    // result_kind, degenerate
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SQ, ST_ROOT, ST_NORM, ST_GNORM, ST_DIV, ST_PROD, ST_FIN
    } state_t;

    state_t                state_reg;
    logic [COORD_BITS-1:0] lm_reg [3];
    logic [COORD_BITS-1:0] pt_reg [3];
    logic                  sel_reg;
    logic [MAG_BITS-1:0]   mag_reg [3];
    logic                  neg_reg [3];
    logic [2*MAG_BITS-1:0] acc_reg;
    logic [2*MAG_BITS-1:0] prod_reg;
    logic [1:0]            cnt_reg;
    logic [1:0]            pass_reg;
    logic [2:0]            div_idx_reg;
    logic [4:0]            shift_reg;
    logic [30:0]           gx_reg;
    logic [30:0]           gy_reg;
    logic [31:0]           dist_reg;
    logic [31:0]           len_reg;
    logic [31:0]           hg_reg;
    logic [31:0]           f_reg [3];
    logic [31:0]           c_reg;
    logic [31:0]           sn_reg;
    logic [31:0]           hz_reg;
    logic [63:0]           pc_reg;
    logic [63:0]           ps_reg;
    logic                  deg_reg;
    logic                  kind_reg;
    logic                  root_start_reg;
    logic                  div_start_reg;
    logic                  out_valid_reg;
    logic [175:0]          out_data_reg;
    logic [1:0]            out_user_reg;

    logic [MAG_BITS-1:0]   m_max;
    logic [MAG_BITS-1:0]   mul_a;
    logic [MAG_BITS-1:0]   mul_b;
    logic [1:0]            n_terms;
    logic [63:0]           div_n;
    logic [63:0]           div_d;
    logic [31:0]           quo_clamped;
    logic [143:0]          frame;
    logic [ROOT_BITS-1:0]  root;
    logic                  root_done;
    logic                  root_busy;
    logic [QUO_BITS-1:0]   quo;
    logic                  div_done;
    logic                  div_busy;
    logic                  in_beat;
    logic                  out_free;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        m_max = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        if (mag_reg[2] > m_max)
            m_max = mag_reg[2];
    end

    assign n_terms = (pass_reg == 2'd2) ? 2'd2 : 2'd3;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_PROD)
        begin
            mul_a = (cnt_reg == 2'd0) ? {1'b0, c_reg} : {1'b0, sn_reg};
            mul_b = {1'b0, f_reg[2]};
        end
        else if (pass_reg == 2'd2)
        begin
            mul_a = (cnt_reg == 2'd0) ? {2'b0, gx_reg} : {2'b0, gy_reg};
            mul_b = mul_a;
        end
        else
        begin
            case (cnt_reg)
                2'd0:    mul_a = mag_reg[0];
                2'd1:    mul_a = mag_reg[1];
                2'd2:    mul_a = mag_reg[2];
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    always_comb
    begin
        case (div_idx_reg)
            3'd0:    div_n = {2'b0, mag_reg[0][30:0], 31'b0};
            3'd1:    div_n = {2'b0, mag_reg[1][30:0], 31'b0};
            3'd2:    div_n = {2'b0, mag_reg[2][30:0], 31'b0};
            3'd3:    div_n = {2'b0, gx_reg, 31'b0};
            3'd4:    div_n = {2'b0, gy_reg, 31'b0};
            3'd5:    div_n = {1'b0, hg_reg, 31'b0};
            default: div_n = '0;
        endcase
        case (div_idx_reg)
            3'd3, 3'd4: div_d = {32'b0, hg_reg};
            3'd5:       div_d = {32'b0, len_reg} << shift_reg;
            default:    div_d = {32'b0, len_reg};
        endcase
    end

    assign quo_clamped = (quo > {1'b0, 32'h8000_0000}) ? 32'h8000_0000 : quo[31:0];

    always_comb
    begin
        frame = {
            to_axis(f_reg[2], neg_reg[2]),
            to_axis(f_reg[1], neg_reg[1]),
            to_axis(f_reg[0], neg_reg[0]),
            16'd0,
            to_axis(c_reg, neg_reg[0]),
            to_axis(sn_reg, !neg_reg[1]),
            to_axis(hz_reg, 1'b1),
            prod_axis(ps_reg, neg_reg[1] ^ neg_reg[2]),
            prod_axis(pc_reg, neg_reg[0] ^ neg_reg[2])
        };
        if (deg_reg)
            frame = '0;
    end

    ptlf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_reg),
        .radicand ({2'b0, acc_reg}),
        .root     (root),
        .done     (root_done),
        .busy     (root_busy)
    );

    ptlf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   ({1'b0, div_n, 1'b0} + {2'b0, div_d}),
        .den   ({div_d, 1'b0}),
        .quo   (quo),
        .done  (div_done),
        .busy  (div_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sel_reg        <= 1'b0;
            root_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            pass_reg       <= '0;
            div_idx_reg    <= '0;
            kind_reg       <= KIND_MEASURE;
            deg_reg        <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                lm_reg[i] <= '0;
                pt_reg[i] <= '0;
            end
        end
        else
        begin
            root_start_reg <= (state_reg == ST_SQ) && (cnt_reg == n_terms);
            div_start_reg  <= ((state_reg == ST_ROOT) && root_done && pass_reg[1])
                              || ((state_reg == ST_DIV) && div_done && (div_idx_reg != 3'd5));
            if (out_valid_reg && m_axis_tready && (state_reg != ST_FIN))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        kind_reg <= (s_axis_tuser == OP_CLEAR) ? KIND_CLEARED : KIND_MEASURE;
                        deg_reg  <= 1'b0;
                        case (s_axis_tuser)
                            OP_SET_LANDMARK:
                            begin
                                lm_reg[0] <= s_axis_tdata[31:0];
                                lm_reg[1] <= s_axis_tdata[63:32];
                                lm_reg[2] <= s_axis_tdata[95:64];
                                sel_reg   <= 1'b1;
                                state_reg <= ST_DIFF;
                            end
                            OP_CLEAR:
                            begin
                                sel_reg   <= 1'b0;
                                state_reg <= ST_FIN;
                            end
                            OP_NEW_POINT:
                            begin
                                pt_reg[0] <= s_axis_tdata[31:0];
                                pt_reg[1] <= s_axis_tdata[63:32];
                                pt_reg[2] <= s_axis_tdata[95:64];
                                if (sel_reg)
                                    state_reg <= ST_DIFF;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIFF:
                begin
                    pass_reg  <= 2'd0;
                    cnt_reg   <= 2'd0;
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == n_terms)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        case (pass_reg)
                            2'd0:
                            begin
                                if (m_max == '0)
                                begin
                                    deg_reg   <= 1'b1;
                                    state_reg <= ST_FIN;
                                end
                                else
                                begin
                                    state_reg <= ST_NORM;
                                end
                            end
                            2'd1:
                            begin
                                state_reg <= ST_GNORM;
                            end
                            default:
                            begin
                                div_idx_reg <= 3'd0;
                                state_reg   <= ST_DIV;
                            end
                        endcase
                    end
                end
                ST_NORM:
                begin
                    if (m_max[MAG_BITS-1] == 1'b0 && m_max[MAG_BITS-2] == 1'b0
                        && m_max[MAG_BITS-3] == 1'b1)
                    begin
                        if (mag_reg[0] == '0 && mag_reg[1] == '0)
                        begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            pass_reg  <= 2'd1;
                            cnt_reg   <= 2'd0;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_GNORM:
                begin
                    if (gx_reg[30] || gy_reg[30])
                    begin
                        pass_reg  <= 2'd2;
                        cnt_reg   <= 2'd0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_idx_reg == 3'd5)
                        begin
                            cnt_reg   <= 2'd0;
                            state_reg <= ST_PROD;
                        end
                        else
                        begin
                            div_idx_reg <= div_idx_reg + 3'd1;
                        end
                    end
                end
                ST_PROD:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic [MAG_BITS-1:0] d;
                    d = {lm_reg[i][COORD_BITS-1], lm_reg[i]}
                        - {pt_reg[i][COORD_BITS-1], pt_reg[i]};
                    neg_reg[i] <= d[MAG_BITS-1];
                    mag_reg[i] <= d[MAG_BITS-1] ? -d : d;
                end
                acc_reg <= '0;
            end
            ST_SQ:
            begin
                if (cnt_reg != 2'd0)
                    acc_reg <= acc_reg + prod_reg;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    case (pass_reg)
                        2'd0:
                            dist_reg <= (root[ROOT_BITS-1 -: 2] != 2'b0) ? 32'hFFFF_FFFF
                                                                          : root[31:0];
                        2'd1:
                        begin
                            len_reg   <= root[31:0];
                            gx_reg    <= mag_reg[0][30:0];
                            gy_reg    <= mag_reg[1][30:0];
                            shift_reg <= '0;
                        end
                        default:
                            hg_reg <= root[31:0];
                    endcase
                    acc_reg <= '0;
                end
            end
            ST_NORM:
            begin
                if (m_max[MAG_BITS-1] || m_max[MAG_BITS-2])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!m_max[MAG_BITS-3])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            ST_GNORM:
            begin
                if (!gx_reg[30] && !gy_reg[30])
                begin
                    gx_reg    <= gx_reg << 1;
                    gy_reg    <= gy_reg << 1;
                    shift_reg <= shift_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (div_idx_reg)
                        3'd0:    f_reg[0] <= quo_clamped;
                        3'd1:    f_reg[1] <= quo_clamped;
                        3'd2:    f_reg[2] <= quo_clamped;
                        3'd3:    c_reg    <= quo_clamped;
                        3'd4:    sn_reg   <= quo_clamped;
                        default: hz_reg   <= quo_clamped;
                    endcase
                end
            end
            ST_PROD:
            begin
                if (cnt_reg == 2'd1)
                    pc_reg <= prod_reg[63:0];
                if (cnt_reg == 2'd2)
                    ps_reg <= prod_reg[63:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg <= (kind_reg == KIND_CLEARED) ? '0 : {frame, dist_reg};
                    out_user_reg <= {deg_reg && (kind_reg == KIND_MEASURE), kind_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `PTLF_ASSERT_IMPL(a_clear_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tuser[1], "cleared beat carries data")
    `PTLF_ASSERT_NEVER(a_deg_frame, m_axis_tvalid && m_axis_tuser[1] && m_axis_tdata[175:32] != '0, "degenerate beat with nonzero frame")
    `PTLF_ASSERT_NEVER(a_units_excl, root_busy && div_busy, "root and divide units busy together")
endmodule

// File: tb/point_to_landmark_lookat_frame_unit_tb.sv
// Self-checking testbench for point_to_landmark_lookat_frame_unit: distance and look-at frame
// predicted in fixed point for each beat that yields a result, compared against the output.
// Depends on ptlf_pkg and the DUT sources only.
`timescale 1ns / 1ps
module point_to_landmark_lookat_frame_unit_tb;
    import ptlf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 3000;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          drain;
    } cmd_t;

    typedef struct {
        logic        kind;
        logic [31:0] dist_val;
        logic        degen;
        logic [15:0] ax[9];
    } meas_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    cmd_t        cmd_q[$];
    meas_t       meas_q[$];
    logic [31:0] lmk[3];
    logic [31:0] trk[3];
    bit          lmk_sel;
    int          gap_cnt;
    int          hold_cnt;
    bit          hold_done;
    int          idle_cycles;
    int          err_cnt;
    int          n_meas;
    int          n_degen;
    int          n_clear;
    int          n_beats;

    string ax_name[9] = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                          "front_x", "front_y", "front_z"};

    point_to_landmark_lookat_frame_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= s)
                r = c;
        end
        return r;
    endfunction

    // n / d rounded half up, clamped to 1.0 in Q.31
    function automatic logic [63:0] unit_quot(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        q = (2 * n + d) / (2 * d);
        return (q > (128'd1 << UNIT_FRAC)) ? (64'd1 << UNIT_FRAC) : q[63:0];
    endfunction

    function automatic logic [15:0] round_unit(input logic [63:0] q, input logic neg);
        logic [63:0] r;
        r = (q + (64'd1 << 16)) >> 17;
        return neg ? 16'(-r) : r[15:0];
    endfunction

    function automatic logic [15:0] round_prod(input logic [63:0] a, input logic [63:0] b,
                                               input logic neg);
        logic [127:0] r;
        r = (128'(a) * 128'(b) + (128'd1 << 47)) >> 48;
        return neg ? 16'(-r) : r[15:0];
    endfunction

    function automatic meas_t lookat_frame();
        meas_t        r;
        logic [63:0]  d64;
        logic [63:0]  mag[3];
        logic         neg[3];
        logic [63:0]  f[3];
        logic [127:0] s;
        logic [63:0]  m, root, lnorm, gx, gy, mxy, hg, c, sn, hz;
        int           t;
        r.kind  = KIND_MEASURE;
        r.degen = 1'b0;
        foreach (r.ax[k]) r.ax[k] = '0;
        s = '0;
        m = '0;
        t = 0;
        for (int i = 0; i < 3; i++) begin
            d64    = {{32{lmk[i][31]}}, lmk[i]} - {{32{trk[i][31]}}, trk[i]};
            neg[i] = d64[63];
            mag[i] = neg[i] ? -d64 : d64;
            s      = s + 128'(mag[i]) * 128'(mag[i]);
            if (mag[i] > m) m = mag[i];
        end
        root       = isqrt(s);
        r.dist_val = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
        if (m == 0) begin
            r.degen = 1'b1;
            return r;
        end
        while (m >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            m = m << 1;
        end
        if (mag[0] == 0 && mag[1] == 0) begin
            r.degen = 1'b1;
            return r;
        end
        lnorm = isqrt(128'(mag[0]) * mag[0] + 128'(mag[1]) * mag[1] + 128'(mag[2]) * mag[2]);
        for (int i = 0; i < 3; i++)
            f[i] = unit_quot(128'(mag[i]) << 31, 128'(lnorm));
        gx  = mag[0];
        gy  = mag[1];
        mxy = (gx > gy) ? gx : gy;
        while (mxy < (64'd1 << 30)) begin
            gx  = gx << 1;
            gy  = gy << 1;
            mxy = mxy << 1;
            t++;
        end
        hg = isqrt(128'(gx) * gx + 128'(gy) * gy);
        c  = unit_quot(128'(gx) << 31, 128'(hg));
        sn = unit_quot(128'(gy) << 31, 128'(hg));
        hz = unit_quot(128'(hg) << 31, 128'(lnorm) << t);
        r.ax[0] = round_prod(c, f[2], neg[0] ^ neg[2]);
        r.ax[1] = round_prod(sn, f[2], neg[1] ^ neg[2]);
        r.ax[2] = round_unit(hz, 1'b1);
        r.ax[3] = round_unit(sn, !neg[1]);
        r.ax[4] = round_unit(c, neg[0]);
        r.ax[5] = '0;
        for (int i = 0; i < 3; i++)
            r.ax[6 + i] = round_unit(f[i], neg[i]);
        return r;
    endfunction

    task automatic apply_cmd(input cmd_t cm);
        meas_t r;
        case (cm.op)
            OP_SET_LANDMARK: begin
                lmk     = '{cm.x, cm.y, cm.z};
                lmk_sel = 1'b1;
                meas_q.push_back(lookat_frame());
            end
            OP_CLEAR: begin
                lmk_sel    = 1'b0;
                r.kind     = KIND_CLEARED;
                r.dist_val = '0;
                r.degen    = 1'b0;
                foreach (r.ax[k]) r.ax[k] = '0;
                meas_q.push_back(r);
            end
            OP_NEW_POINT: begin
                trk = '{cm.x, cm.y, cm.z};
                if (lmk_sel) meas_q.push_back(lookat_frame());
            end
            default: ;
        endcase
    endtask

    function automatic int rand_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        cmd_t cm;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            gap_cnt       = 0;
            lmk           = '{32'd0, 32'd0, 32'd0};
            trk           = '{32'd0, 32'd0, 32'd0};
            lmk_sel       = 1'b0;
            n_beats       = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                cm.op = s_axis_tuser;
                cm.x  = s_axis_tdata[31:0];
                cm.y  = s_axis_tdata[63:32];
                cm.z  = s_axis_tdata[95:64];
                apply_cmd(cm);
                n_beats++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && meas_q.size() != 0)) begin
                    cm = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cm.op;
                    s_axis_tdata  <= {cm.z, cm.y, cm.x};
                    gap_cnt       = rand_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        meas_t ex;
        logic [15:0] got;
        bit bad;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt      = 0;
            hold_done     = 1'b0;
            err_cnt       = 0;
            n_meas        = 0;
            n_degen       = 0;
            n_clear       = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (meas_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: result beat with no expectation, tdata=%h tuser=%b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    ex  = meas_q.pop_front();
                    bad = 1'b0;
                    if (m_axis_tuser[0] !== ex.kind || m_axis_tuser[1] !== ex.degen
                        || m_axis_tdata[31:0] !== ex.dist_val) begin
                        bad = 1'b1;
                        if (err_cnt < 10)
                            $display("ERROR: kind/degenerate/distance exp %b/%b/%h got %b/%b/%h",
                                     ex.kind, ex.degen, ex.dist_val,
                                     m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[31:0]);
                    end
                    for (int k = 0; k < 9; k++) begin
                        got = m_axis_tdata[32 + 16*k +: 16];
                        if (got !== ex.ax[k]) begin
                            if (err_cnt < 10 && !bad)
                                $display("ERROR: %s exp %h got %h", ax_name[k], ex.ax[k], got);
                            bad = 1'b1;
                        end
                    end
                    if (bad) err_cnt++;
                    if (ex.kind == KIND_CLEARED) n_clear++;
                    else if (ex.degen) n_degen++;
                    else n_meas++;
                    if (!hold_done && n_meas == 150) begin
                        hold_done = 1'b1;
                        hold_cnt  = LONG_HOLD;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < 4) begin
                hold_cnt = rand_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", meas_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord(input logic [31:0] base);
        int p;
        p = $urandom_range(99);
        if (p < 40) return $urandom();
        if (p < 65) return base + 32'($signed($urandom_range(2000)) - 1000);
        if (p < 80) return base + 32'($signed($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000);
        if (p < 88) return base;
        if (p < 94) return {1'b0, {31{1'b1}}};
        return {1'b1, 31'd0};
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input bit drain);
        cmd_t cm;
        cm = '{op, x, y, z, drain};
        cmd_q.push_back(cm);
    endtask

    initial begin
        logic [31:0] bx, by, bz;
        logic [1:0]  op;
        int          p;
        rst_n       = 1'b0;
        // directed
        push_cmd(OP_NEW_POINT, 32'h0001_0000, 32'd0, 32'd0, 0);      // no landmark yet
        push_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);                   // clear when none selected
        push_cmd(OP_SET_LANDMARK, 32'h0001_0000, 32'd0, 32'd0, 0);    // point coincides
        push_cmd(OP_NEW_POINT, 32'h0001_0000, 32'd0, 32'd0, 0);       // zero direction
        push_cmd(OP_NEW_POINT, 32'h0001_0000, 32'd0, 32'h0005_0000, 0); // along -z
        push_cmd(OP_NEW_POINT, 32'h0001_0000, 32'd0, 32'hFFF0_0000, 0); // along +z
        push_cmd(2'd3, 32'hDEAD_BEEF, 32'd1, 32'd2, 0);               // unknown opcode
        push_cmd(OP_SET_LANDMARK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        push_cmd(OP_NEW_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0); // saturates
        push_cmd(OP_NEW_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        push_cmd(OP_SET_LANDMARK, 32'd1, 32'd0, 32'd0, 0);
        push_cmd(OP_NEW_POINT, 32'd0, 32'd0, 32'd0, 0);               // one lsb along x
        push_cmd(OP_NEW_POINT, 32'd1, 32'd1, 32'd0, 0);               // one lsb along -y
        push_cmd(OP_NEW_POINT, 32'd0, 32'd1, 32'hFFFF_FFFF, 0);
        push_cmd(OP_NEW_POINT, 32'd1, 32'd0, 32'h7FFF_FFFF, 0);       // zero xy, huge z
        push_cmd(OP_SET_LANDMARK, 32'hFFFF_FFFF, 32'h0000_0003, 32'h7FFF_FFFF, 0);
        push_cmd(OP_NEW_POINT, 32'h0000_0004, 32'hFFFF_FFFC, 32'h8000_0000, 0);
        push_cmd(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);
        push_cmd(OP_NEW_POINT, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0);
        push_cmd(OP_SET_LANDMARK, 32'h0003_0000, 32'hFFFC_0000, 32'h0002_0000, 1);
        // random: mostly tracking sequences around the current landmark
        bx = 0; by = 0; bz = 0;
        for (int n = 0; n < 1000; n++) begin
            p = $urandom_range(99);
            if (p < 12) op = OP_SET_LANDMARK;
            else if (p < 18) op = OP_CLEAR;
            else if (p < 21) op = 2'd3;
            else op = OP_NEW_POINT;
            if (op == OP_SET_LANDMARK) begin
                bx = $urandom(); by = $urandom(); bz = $urandom();
                push_cmd(op, bx, by, bz, (n % 250) == 249);
            end else if (op == OP_NEW_POINT && $urandom_range(9) == 0) begin
                push_cmd(op, bx, by, rand_coord(bz), (n % 250) == 249);  // on the z axis
            end else begin
                push_cmd(op, rand_coord(bx), rand_coord(by), rand_coord(bz), (n % 250) == 249);
            end
        end
        repeat (8) @(posedge clk);
        rst_n = 1'b1;
        while (cmd_q.size() != 0 || s_axis_tvalid || meas_q.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        $display("Accepted %0d input beats; checked %0d frames, %0d degenerate, %0d clears",
                 n_beats, n_meas, n_degen, n_clear);
        if (err_cnt == 0 && meas_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
